[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the deque checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// antecedent true implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[sv/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// types and constants of the bounded deque with positional insert
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;
   localparam int OPCODE_W = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic load;
      logic take_prev;
      logic take_next;
   } cell_ctrl_type;

endpackage

[sv/bdq_req_if.sv]
// ----------------------------------------------------------------------------
// bdq_req_if
// operation channel: opcode, value and insert index
// ----------------------------------------------------------------------------
interface bdq_req_if;

   logic                                valid;
   logic                                ready;
   logic [bdq_pkg::OPCODE_W-1:0]        opcode;
   logic signed [bdq_pkg::DATA_W-1:0]   data_value;
   logic [bdq_pkg::POS_W-1:0]           position;

   modport source (output valid, opcode, data_value, position, input ready);
   modport sink   (input valid, opcode, data_value, position, output ready);

endinterface

[sv/bdq_rsp_if.sv]
// ----------------------------------------------------------------------------
// bdq_rsp_if
// result channel: popped value, status and fill count
// ----------------------------------------------------------------------------
interface bdq_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [bdq_pkg::DATA_W-1:0]   popped_value;
   logic [bdq_pkg::STATUS_W-1:0]        status;
   logic [bdq_pkg::FILL_W-1:0]          fill_count;

   modport source (output valid, popped_value, status, fill_count, input ready);
   modport sink   (input valid, popped_value, status, fill_count, output ready);

endinterface

[sv/bounded_deque_with_positional_insert.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_insert
// deque of signed values with push, pop and insert at an index
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while req.ready is high; each item gives one
// result in the cycle after it is accepted. The slots form a row of cells,
// and the cells that move all shift by one place at the same clock edge, so a
// push, insert or pop costs the same whatever the position. The result sits
// in an output register; req.ready is high while it is empty or being taken.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_insert (
   input  logic clock,
   input  logic reset,
   bdq_req_if.sink   req,
   bdq_rsp_if.source rsp
);

   bdq_pkg::cell_ctrl_type            cell_ctrl  [bdq_pkg::DEPTH];
   logic signed [bdq_pkg::DATA_W-1:0] slot_value [bdq_pkg::DEPTH];

   logic [bdq_pkg::CNT_W-1:0]    occupancy_ff;
   logic [bdq_pkg::CNT_W-1:0]    occupancy_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [bdq_pkg::DATA_W-1:0] popped_ff;
   logic signed [bdq_pkg::DATA_W-1:0] popped_in;
   logic [bdq_pkg::STATUS_W-1:0] status_ff;
   logic [bdq_pkg::STATUS_W-1:0] status_in;
   logic [bdq_pkg::FILL_W-1:0]   fill_ff;
   logic [bdq_pkg::FILL_W-1:0]   fill_in;

   logic                         req_accept;
   logic                         is_full;
   logic                         is_empty;
   logic                         do_put;
   logic                         do_pop_front;
   logic [bdq_pkg::CMP_W-1:0]    occ_ext;
   logic [bdq_pkg::CMP_W-1:0]    pos_ext;
   logic [bdq_pkg::CMP_W-1:0]    ins_ext;
   logic [bdq_pkg::IDX_W-1:0]    ins_idx;
   logic [bdq_pkg::IDX_W-1:0]    last_idx;

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   assign is_full  = (occupancy_ff == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
   assign is_empty = (occupancy_ff == '0);
   assign occ_ext  = bdq_pkg::CMP_W'(occupancy_ff);
   assign pos_ext  = bdq_pkg::CMP_W'(req.position);
   assign last_idx = bdq_pkg::IDX_W'(occupancy_ff - 1'b1);
   assign ins_idx  = ins_ext[bdq_pkg::IDX_W-1:0];

   // operation decode
   always_comb begin
      do_put       = 1'b0;
      do_pop_front = 1'b0;
      status_in    = bdq_pkg::ST_OK;
      popped_in    = '0;
      occupancy_in = occupancy_ff;
      ins_ext      = '0;
      unique case (req.opcode) inside
         bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_INSERT: begin
            if (is_full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               do_put       = 1'b1;
               occupancy_in = occupancy_ff + 1'b1;
               if (req.opcode == bdq_pkg::OP_PUSH_FRONT || is_empty) begin
                  ins_ext = '0;
               end else if (req.opcode == bdq_pkg::OP_PUSH_BACK) begin
                  ins_ext = occ_ext;
               end else begin
                  ins_ext = (pos_ext == '0) ? bdq_pkg::CMP_W'(1) : pos_ext;
                  if (ins_ext > occ_ext) begin
                     ins_ext = occ_ext;
                  end
               end
            end
         end
         bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
            if (is_empty) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               occupancy_in = occupancy_ff - 1'b1;
               if (req.opcode == bdq_pkg::OP_POP_FRONT) begin
                  do_pop_front = 1'b1;
                  popped_in    = slot_value[0];
               end else begin
                  popped_in = slot_value[last_idx];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign fill_in = bdq_pkg::FILL_W'(occupancy_in);

   // per-cell shift controls
   always_comb begin
      for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
         cell_ctrl[i].load      = req_accept && do_put
                                  && (bdq_pkg::IDX_W'(i) == ins_idx);
         cell_ctrl[i].take_prev = req_accept && do_put
                                  && (bdq_pkg::IDX_W'(i) > ins_idx);
         cell_ctrl[i].take_next = req_accept && do_pop_front;
      end
   end

   for (genvar g = 0; g < bdq_pkg::DEPTH; g++) begin : g_cell
      logic signed [bdq_pkg::DATA_W-1:0] prev_value;
      logic signed [bdq_pkg::DATA_W-1:0] next_value;

      if (g == 0) begin : g_first
         assign prev_value = req.data_value;
      end else begin : g_prev
         assign prev_value = slot_value[g-1];
      end

      if (g == bdq_pkg::DEPTH - 1) begin : g_last
         assign next_value = slot_value[g];
      end else begin : g_next
         assign next_value = slot_value[g+1];
      end

      bdq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .data_value (req.data_value),
         .prev_value (prev_value),
         .next_value (next_value),
         .slot_value (slot_value[g])
      );
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         occupancy_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            occupancy_ff <= occupancy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.popped_value = popped_ff;
   assign rsp.status       = status_ff;
   assign rsp.fill_count   = fill_ff;

endmodule

[sv/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell
// one slot of the deque; loads, shifts from a neighbor or holds
// ----------------------------------------------------------------------------
module bdq_cell (
   input  logic                                clock,
   input  bdq_pkg::cell_ctrl_type              ctrl,
   input  logic signed [bdq_pkg::DATA_W-1:0]   data_value,
   input  logic signed [bdq_pkg::DATA_W-1:0]   prev_value,
   input  logic signed [bdq_pkg::DATA_W-1:0]   next_value,
   output logic signed [bdq_pkg::DATA_W-1:0]   slot_value
);

   logic signed [bdq_pkg::DATA_W-1:0] slot_ff;
   logic signed [bdq_pkg::DATA_W-1:0] slot_in;

   always_comb begin
      if (ctrl.load) begin
         slot_in = data_value;
      end else if (ctrl.take_prev) begin
         slot_in = prev_value;
      end else if (ctrl.take_next) begin
         slot_in = next_value;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_value = slot_ff;

endmodule

[sv/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks of the deque, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [bdq_pkg::DATA_W-1:0]   rsp_popped_value,
   input logic [bdq_pkg::STATUS_W-1:0]        rsp_status,
   input logic [bdq_pkg::FILL_W-1:0]          rsp_fill_count
);

   logic req_take;
   logic rsp_stall;
   logic rsp_empty;
   logic rsp_full;
   logic pop_zero;
   logic fill_zero;
   logic fill_top;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_empty = rsp_valid && (rsp_status == bdq_pkg::ST_EMPTY);
   assign rsp_full  = rsp_valid && (rsp_status == bdq_pkg::ST_FULL);
   assign pop_zero  = (rsp_popped_value == '0);
   assign fill_zero = (rsp_fill_count == '0);
   assign fill_top  = (rsp_fill_count == bdq_pkg::FILL_W'(bdq_pkg::DEPTH));

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fill_count))
   `ASSERT_NEXT(a_item_gives_result, clock, reset, req_take, rsp_valid)
   `ASSERT_IMPLY(a_empty_result, clock, reset, rsp_empty, pop_zero && fill_zero)
   `ASSERT_IMPLY(a_full_result, clock, reset, rsp_full, pop_zero && fill_top)
   `ASSERT_IMPLY(a_no_ready_when_stalled, clock, reset, rsp_stall, !req_ready)

endmodule

bind bounded_deque_with_positional_insert bdq_checker u_bdq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_popped_value (rsp.popped_value),
   .rsp_status       (rsp.status),
   .rsp_fill_count   (rsp.fill_count)
);
